[hw/rtl/ilist_pkg.sv]
// Shared types and codes for the indexed list engine.
package ilist_pkg;

	localparam int OPC_W  = 3;
	localparam int POS_W  = 8;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int TOT_W  = 9;

	localparam logic [OPC_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OPC_W-1:0] OP_INSERT  = 3'd1;
	localparam logic [OPC_W-1:0] OP_REPLACE = 3'd2;
	localparam logic [OPC_W-1:0] OP_REMOVE  = 3'd3;
	localparam logic [OPC_W-1:0] OP_READ    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [OPC_W-1:0]         opcode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] read_value;
		logic [TOT_W-1:0]         element_total;
	} rsp_t;

endpackage

[hw/rtl/indexed_list_insert_remove_engine.sv]
// Indexed list engine: top level with the request sequencer.
//
// Holds an ordered list of signed 32-bit values in a single-port-write,
// registered-read store of MAX_ENTRIES slots. One request is worked on at a
// time; req_stall is high from acceptance until the result has been loaded
// into the output register. Append, replace, rejected and unused requests
// go from evaluation to the result, read first waits for the store. The
// result becomes valid in the same cycle in which the next request can be
// taken. Insert moves count - position elements and remove moves count -
// position - 1 elements; the store moves one element per cycle through one
// shared pointer stepper. A result held by rsp_stall keeps the sequencer
// waiting and delays the next request.
// The store needs no clearing after reset; only written slots are read.
module indexed_list_insert_remove_engine import ilist_pkg::*; #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_RWAIT = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]               state_q;
	logic [CW-1:0]            count_q;
	logic [OPC_W-1:0]         op_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic [STAT_W-1:0]        st_q;
	logic signed [DATA_W-1:0] rd_q;
	logic [CW-1:0]            rp_q;
	logic [CW-1:0]            lag_q;
	logic [CW-1:0]            wa_s1;
	logic                     pend_s1;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic [CW-1:0]            pos_c;
	logic                     pos_ok;
	logic                     full;
	logic                     ins;
	logic                     last;
	logic [CW-1:0]            step_a;
	logic                     step_dec;
	logic [CW-1:0]            step_res;
	logic                     we;
	logic [AW-1:0]            wa;
	logic signed [DATA_W-1:0] wd;
	logic                     re;
	logic [AW-1:0]            ra;
	logic signed [DATA_W-1:0] rdata;

	assign pos_c  = CW'(pos_q);
	assign pos_ok = PW'(pos_q) < PW'(count_q);
	assign full   = count_q == CW'(MAX_ENTRIES);
	assign ins    = op_q == OP_INSERT;
	assign last   = ins ? (rp_q == pos_c) : (step_res == count_q);

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	ilist_step #(.W(CW)) u_step (
		.a   (step_a),
		.dec (step_dec),
		.res (step_res)
	);

	ilist_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
		.clk       (clk),
		.we        (we),
		.wa        (wa),
		.wd        (wd),
		.re        (re),
		.ra        (ra),
		.rd_data_q (rdata)
	);

	always_comb begin
		step_a   = count_q;
		step_dec = 1'b0;
		case (state_q)
			S_EVAL: begin
				if (op_q == OP_INSERT) begin
					step_dec = 1'b1;
				end else if (op_q == OP_REMOVE) begin
					step_a = pos_c;
				end
			end
			S_SHIFT: begin
				step_a   = rp_q;
				step_dec = ins;
			end
			S_DRAIN: begin
				step_dec = 1'b1;
			end
			default: begin
				step_a   = count_q;
				step_dec = 1'b0;
			end
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = count_q[AW-1:0];
		wd = val_q;
		re = 1'b0;
		ra = pos_c[AW-1:0];
		case (state_q)
			S_EVAL: begin
				if (op_q == OP_APPEND) begin
					we = !full;
				end else if (op_q == OP_REPLACE) begin
					we = pos_ok;
					wa = pos_c[AW-1:0];
				end else if (op_q == OP_READ) begin
					re = pos_ok;
				end
			end
			S_SHIFT: begin
				re = 1'b1;
				ra = rp_q[AW-1:0];
				we = pend_s1;
				wa = wa_s1[AW-1:0];
				wd = rdata;
			end
			S_DRAIN: begin
				we = pend_s1;
				wa = wa_s1[AW-1:0];
				wd = rdata;
			end
			S_PUT: begin
				we = 1'b1;
				wa = pos_c[AW-1:0];
			end
			default: begin
				we = 1'b0;
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= req_data.opcode;
				pos_q <= req_data.position;
				val_q <= req_data.item_value;
			end
			S_EVAL: begin
				rd_q  <= '0;
				rp_q  <= step_res;
				lag_q <= ins ? count_q : pos_c;
				case (op_q)
					OP_APPEND: begin
						st_q <= full ? ST_FULL : ST_OK;
					end
					OP_INSERT: begin
						st_q <= !pos_ok ? ST_BAD : (full ? ST_FULL : ST_OK);
					end
					OP_REPLACE, OP_REMOVE, OP_READ: begin
						st_q <= pos_ok ? ST_OK : ST_BAD;
					end
					default: begin
						st_q <= ST_OK;
					end
				endcase
			end
			S_RWAIT: begin
				rd_q <= rdata;
			end
			S_SHIFT: begin
				wa_s1 <= lag_q;
				lag_q <= rp_q;
				rp_q  <= step_res;
			end
			default: begin
				rd_q <= rd_q;
			end
		endcase
		if (state_q == S_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.status        <= st_q;
			rsp_q.read_value    <= rd_q;
			rsp_q.element_total <= TOT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					pend_s1 <= 1'b0;
					case (op_q)
						OP_APPEND: begin
							state_q <= S_FIN;
							if (!full) begin
								count_q <= step_res;
							end
						end
						OP_INSERT: begin
							state_q <= (pos_ok && !full) ? S_SHIFT : S_FIN;
						end
						OP_REMOVE: begin
							if (pos_ok) begin
								state_q <= (step_res == count_q) ? S_DRAIN : S_SHIFT;
							end else begin
								state_q <= S_FIN;
							end
						end
						OP_READ: begin
							state_q <= pos_ok ? S_RWAIT : S_FIN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_RWAIT: begin
					state_q <= S_FIN;
				end
				S_SHIFT: begin
					pend_s1 <= 1'b1;
					if (last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					pend_s1 <= 1'b0;
					if (ins) begin
						state_q <= S_PUT;
					end else begin
						count_q <= step_res;
						state_q <= S_FIN;
					end
				end
				S_PUT: begin
					count_q <= step_res;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ilist_mem.sv]
// Element store: one write port and one registered read port.
module ilist_mem import ilist_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            wa,
	input  logic signed [DATA_W-1:0] wd,
	input  logic                     re,
	input  logic [AW-1:0]            ra,
	output logic signed [DATA_W-1:0] rd_data_q
);

	logic signed [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[ra];
		end
	end

endmodule

[hw/rtl/ilist_step.sv]
// Shared increment/decrement unit for pointers and the element count.
module ilist_step #(
	parameter int W = 9
) (
	input  logic [W-1:0] a,
	input  logic         dec,
	output logic [W-1:0] res
);

	assign res = dec ? (a - W'(1)) : (a + W'(1));

endmodule

[dv/indexed_list_checker.sv]
// Checker for the indexed list engine: tracks the list, predicts each result and compares it.
`timescale 1ns / 1ps
module indexed_list_checker import ilist_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp_data,
	output int   fail_count,
	output int   outstanding
);

	logic signed [DATA_W-1:0] list_mem [DEPTH];
	logic [TOT_W-1:0]         list_len;
	rsp_t                     expected_q [$];
	int                       fails = 0;
	int                       pending = 0;

	assign fail_count  = fails;
	assign outstanding = pending;

	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		logic pos_ok;
		logic full;
		int   i;
		res = '0;
		pos_ok = r.position < list_len;
		full = list_len >= DEPTH;
		case (r.opcode)
		OP_APPEND: begin
			if (full) begin
				res.status = ST_FULL;
			end else begin
				list_mem[list_len] = r.item_value;
				list_len++;
			end
		end
		OP_INSERT: begin
			if (!pos_ok) begin
				res.status = ST_BAD;
			end else if (full) begin
				res.status = ST_FULL;
			end else begin
				for (i = list_len; i > r.position; i--)
					list_mem[i] = list_mem[i-1];
				list_mem[r.position] = r.item_value;
				list_len++;
			end
		end
		OP_REPLACE: begin
			if (!pos_ok)
				res.status = ST_BAD;
			else
				list_mem[r.position] = r.item_value;
		end
		OP_REMOVE: begin
			if (!pos_ok) begin
				res.status = ST_BAD;
			end else begin
				for (i = r.position; i + 1 < list_len; i++)
					list_mem[i] = list_mem[i+1];
				list_len--;
			end
		end
		OP_READ: begin
			if (!pos_ok)
				res.status = ST_BAD;
			else
				res.read_value = list_mem[r.position];
		end
		default: begin
		end
		endcase
		res.element_total = list_len;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			list_len = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected, actual %p", $time, rsp_data);
					fails++;
				end else begin
					want = expected_q.pop_front();
					if (rsp_data.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, rsp_data.status);
						fails++;
					end
					if (rsp_data.read_value !== want.read_value) begin
						$display("%0t: read_value mismatch, expected %0d, actual %0d",
							$time, want.read_value, rsp_data.read_value);
						fails++;
					end
					if (rsp_data.element_total !== want.element_total) begin
						$display("%0t: element_total mismatch, expected %0d, actual %0d",
							$time, want.element_total, rsp_data.element_total);
						fails++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_q.push_back(apply_request(req_data));
			pending <= expected_q.size();
		end
	end

endmodule

[dv/tb.sv]
// Testbench top for the indexed list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	import ilist_pkg::*;

	localparam int DEPTH       = 256;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 584;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	int   fail_count;
	int   outstanding;
	int   snd_idle = 0;
	int   rcv_idle = 0;
	int   fill = 0;
	int   quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	indexed_list_insert_remove_engine #(.MAX_ENTRIES(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	indexed_list_checker #(.DEPTH(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic issue(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		req_t it;
		it.opcode     = op;
		it.position   = pos;
		it.item_value = val;
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= it;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		case (op)
		OP_APPEND: if (fill < DEPTH) fill++;
		OP_INSERT: if (pos < fill && fill < DEPTH) fill++;
		OP_REMOVE: if (pos < fill) fill--;
		default: begin
		end
		endcase
	endtask

	initial begin
		int                r;
		logic              growing;
		logic [OPC_W-1:0]  op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_READ, 8'd0, 32'h1234_5678);
		issue(OP_REMOVE, 8'd0, '0);
		issue(OP_INSERT, 8'd0, 32'h5555_AAAA);
		issue(OP_REPLACE, 8'd0, 32'hAAAA_5555);
		issue(OP_APPEND, 8'd255, 32'h7FFF_FFFF);
		issue(OP_APPEND, 8'd0, 32'h8000_0000);
		issue(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
		issue(OP_INSERT, 8'd2, 32'd1);
		issue(OP_READ, 8'd0, '0);
		issue(OP_READ, 8'd1, '1);
		issue(OP_READ, 8'd2, '0);
		issue(OP_READ, 8'd3, '0);
		issue(OP_READ, 8'd4, '0);
		issue(OP_REPLACE, 8'd3, '0);
		issue(OP_READ, 8'd3, '0);
		issue(OP_REMOVE, 8'd3, '1);
		issue(OP_REMOVE, 8'd0, '0);
		issue(OP_READ, 8'd0, '0);
		issue(3'd5, 8'd255, '1);
		issue(3'd6, 8'd0, '0);
		issue(3'd7, 8'd1, 32'h8000_0000);
		issue(OP_INSERT, 8'd255, '1);
		issue(OP_REPLACE, 8'd2, 32'h8000_0000);
		issue(OP_READ, 8'd255, '0);

		growing = 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 29 : (ph == 1) ? 69 : 0;
			rcv_idle = (ph == 0) ? 69 : (ph == 1) ? 29 : 0;
			repeat (PHASE_ITEMS) begin
				if (fill == DEPTH && $urandom_range(7) == 0)
					growing = 1'b0;
				if (fill == 0)
					growing = 1'b1;
				r = $urandom_range(99);
				if (growing)
					op = (r < 35) ? OP_APPEND : (r < 65) ? OP_INSERT :
						(r < 75) ? OP_REPLACE : (r < 82) ? OP_REMOVE :
						(r < 95) ? OP_READ : 3'($urandom_range(7, 5));
				else
					op = (r < 8) ? OP_APPEND : (r < 16) ? OP_INSERT :
						(r < 26) ? OP_REPLACE : (r < 71) ? OP_REMOVE :
						(r < 95) ? OP_READ : 3'($urandom_range(7, 5));
				if (fill > 0 && $urandom_range(9) < 8) begin
					case ($urandom_range(3))
					0: pos = '0;
					1: pos = 8'(fill - 1);
					default: pos = 8'($urandom_range(fill - 1));
					endcase
				end else if (fill < DEPTH && $urandom_range(1) == 0) begin
					pos = 8'(fill);
				end else begin
					pos = 8'($urandom_range(255));
				end
				if ($urandom_range(7) == 0) begin
					case ($urandom_range(3))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = '0;
					default: val = '1;
					endcase
				end else begin
					val = $urandom;
				end
				issue(op, pos, val);
			end
			// hold until every result of this phase is back
			req_valid <= 1'b0;
			@(posedge clk);
			while (outstanding != 0)
				@(posedge clk);
		end

		repeat (300) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
